// ===== hdl/rfcmtx_pkg.sv =====
`timescale 1ns / 1ps

package rfcmtx_pkg;

    typedef logic [7:0] t_byte;

    // Longest frame before the check byte: two header bytes, four arguments,
    // two address bytes and the format byte
    localparam int RAW_BYTES = 9;

    // CRC-8/Maxim, reflected polynomial
    localparam t_byte CRC_POLY = 8'h8C;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_REPEAT_COUNT   = 2'd1;
    localparam logic [1:0] REG_GAP_PERIODS    = 2'd2;

    localparam logic [15:0] RESET_DEVICE_ADDRESS = 16'h0000;
    localparam logic [7:0]  RESET_REPEAT_COUNT   = 8'd3;
    localparam logic [2:0]  RESET_GAP_PERIODS    = 3'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,
        ST_PREAMBLE,
        ST_FRAME,
        ST_GAP
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic build_step;
        logic rewind;
        logic rep_dec;
        logic half_flip;
        logic pos_inc;
        logic gap_load;
        logic gap_dec;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic build_last;
        logic half;
        logic pre_last;
        logic frm_last;
        logic bit_value;
        logic gap_one;
        logic gap_cfg_zero;
        logic rep_zero;
    } t_dp_status;

    // One result transfer
    typedef struct packed {
        logic level;
        logic sending;
        logic done;
    } t_result;

endpackage

// ===== hdl/rf_command_frame_manchester_tx_unit.sv =====
`timescale 1ns / 1ps

// Command frame transmitter. A start transfer (mode 1) loads a command and up
// to four argument bytes; every tick transfer (mode 0) yields one half-cell
// line level. Each input transfer gives exactly one result transfer through
// an output register. A start accepted while idle is followed by a build,
// one step per frame byte plus the check byte, during which the input is
// stalled; the build folds one frame byte per cycle into the CRC-8 check
// and writes the frame store one byte per cycle. Starts during a transmission
// are ignored and answered as sending. The configuration registers sit on
// an APB-style port at byte addresses 0 (device address), 4 (repeat count)
// and 8 (gap periods).
module rf_command_frame_manchester_tx_unit
    import rfcmtx_pkg::*;
#(
    parameter int FRAME_BYTES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_command,
    input  logic [2:0]  i_arg_count,
    input  logic [7:0]  i_arg_first,
    input  logic [7:0]  i_arg_second,
    input  logic [7:0]  i_arg_third,
    input  logic [7:0]  i_arg_fourth,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_line_level,
    output logic        o_sending,
    output logic        o_frame_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_device_address;
    logic [7:0]  r_repeat_count;
    logic [2:0]  r_gap_periods;
    logic        r_out_valid;
    t_result     r_result;

    logic        take;
    logic        build_busy;
    t_dp_cmd     dp_cmd;
    t_dp_status  dp_status;
    t_result     result;

    // Write configuration registers on the access cycle
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= RESET_DEVICE_ADDRESS;
            r_repeat_count   <= RESET_REPEAT_COUNT;
            r_gap_periods    <= RESET_GAP_PERIODS;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_DEVICE_ADDRESS: r_device_address <= pwdata[15:0];
                REG_REPEAT_COUNT:   r_repeat_count   <= pwdata[7:0];
                REG_GAP_PERIODS:    r_gap_periods    <= pwdata[2:0];
                default:            ;
            endcase
        end
    end

    // Read back registers
    always_comb begin
        case (paddr[3:2])
            REG_DEVICE_ADDRESS: prdata = {16'd0, r_device_address};
            REG_REPEAT_COUNT:   prdata = {24'd0, r_repeat_count};
            REG_GAP_PERIODS:    prdata = {29'd0, r_gap_periods};
            default:            prdata = 32'd0;
        endcase
    end

    // Accept a transfer unless building or the result register cannot drain
    assign o_in_stall = build_busy || (r_out_valid && i_out_stall);
    assign take       = i_in_valid && !o_in_stall;

    rfcmtx_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_mode       (i_mode),
        .i_status     (dp_status),
        .o_cmd        (dp_cmd),
        .o_result     (result),
        .o_build_busy (build_busy)
    );

    rfcmtx_dpath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_command        (i_command),
        .i_arg_count      (i_arg_count),
        .i_arg_first      (i_arg_first),
        .i_arg_second     (i_arg_second),
        .i_arg_third      (i_arg_third),
        .i_arg_fourth     (i_arg_fourth),
        .i_device_address (r_device_address),
        .i_repeat_count   (r_repeat_count),
        .i_gap_periods    (r_gap_periods),
        .o_status         (dp_status)
    );

    // Hold the result until the far side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_line_level = r_result.level;
    assign o_sending    = r_result.sending;
    assign o_frame_done = r_result.done;

endmodule

// ===== hdl/rfcmtx_ctrl.sv =====
`timescale 1ns / 1ps

module rfcmtx_ctrl
    import rfcmtx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_mode,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output t_result    o_result,
    output logic       o_build_busy
);

    t_state r_state;
    t_state n_state;

    // Hold the segment state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence the segments and form the result of each transfer
    always_comb begin
        logic value;
        logic last;
        value    = 1'b1;
        last     = 1'b0;
        n_state  = r_state;
        o_cmd    = '0;
        o_result = '0;
        o_build_busy = (r_state == ST_BUILD);
        case (r_state)
            ST_IDLE: begin
                if (i_take && i_mode) begin
                    o_cmd.load       = 1'b1;
                    o_result.sending = 1'b1;
                    n_state          = ST_BUILD;
                end
            end
            ST_BUILD: begin
                o_cmd.build_step = 1'b1;
                if (i_status.build_last) begin
                    o_cmd.rewind = 1'b1;
                    n_state      = ST_PREAMBLE;
                end
            end
            ST_PREAMBLE, ST_FRAME: begin
                if (r_state == ST_FRAME) begin
                    value = i_status.bit_value;
                    last  = i_status.frm_last;
                end else begin
                    value = 1'b1;
                    last  = i_status.pre_last;
                end
                if (i_take) begin
                    o_result.sending = 1'b1;
                    if (!i_mode) begin
                        o_cmd.half_flip = 1'b1;
                        o_result.level  = i_status.half ? value : ~value;
                        if (i_status.half) begin
                            if (!last) begin
                                o_cmd.pos_inc = 1'b1;
                            end else if (!i_status.gap_cfg_zero) begin
                                o_cmd.gap_load = 1'b1;
                                n_state        = ST_GAP;
                            end else if (i_status.rep_zero) begin
                                o_result.done = 1'b1;
                                n_state       = ST_IDLE;
                            end else begin
                                o_cmd.rep_dec = 1'b1;
                                o_cmd.rewind  = 1'b1;
                                n_state       = ST_FRAME;
                            end
                        end
                    end
                end
            end
            ST_GAP: begin
                if (i_take) begin
                    o_result.sending = 1'b1;
                    if (!i_mode) begin
                        o_cmd.gap_dec = 1'b1;
                        if (i_status.gap_one) begin
                            if (i_status.rep_zero) begin
                                o_result.done = 1'b1;
                                n_state       = ST_IDLE;
                            end else begin
                                o_cmd.rep_dec = 1'b1;
                                o_cmd.rewind  = 1'b1;
                                n_state       = ST_FRAME;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/rfcmtx_dpath.sv =====
`timescale 1ns / 1ps

module rfcmtx_dpath
    import rfcmtx_pkg::*;
#(
    parameter int FRAME_BYTES = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic [7:0]  i_command,
    input  logic [2:0]  i_arg_count,
    input  logic [7:0]  i_arg_first,
    input  logic [7:0]  i_arg_second,
    input  logic [7:0]  i_arg_third,
    input  logic [7:0]  i_arg_fourth,
    input  logic [15:0] i_device_address,
    input  logic [7:0]  i_repeat_count,
    input  logic [2:0]  i_gap_periods,
    output t_dp_status  o_status
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [4:0] STORE_DEPTH = 5'(FRAME_BYTES);

    // One CRC-8/Maxim byte update, bit by bit
    function automatic t_byte crc_byte(input t_byte crc, input t_byte data);
        t_byte c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    t_byte       r_raw [RAW_BYTES];
    t_byte       r_store [FRAME_BYTES];
    logic [3:0]  r_raw_cnt;
    logic [3:0]  r_build_idx;
    t_byte       r_crc;
    logic [3:0]  r_frame_len;
    logic [2:0]  r_shift;
    logic        r_toggle;
    logic [6:0]  r_pos;
    logic        r_half;
    logic [7:0]  r_repeats;
    logic [2:0]  r_gap;

    t_byte       n_raw [RAW_BYTES];
    logic [3:0]  n_raw_cnt;
    logic        is_long;
    t_byte       build_data;
    logic        build_last;
    logic [4:0]  len_full;
    logic [6:0]  len_bits;
    logic [6:0]  q_pos;
    logic        bit_value;

    assign is_long = (i_command[7:4] != 4'd0);

    // Lay out the frame bytes ahead of the check byte
    always_comb begin
        t_byte      args [4];
        t_byte      hdr0;
        t_byte      fmt;
        logic [3:0] hlen;
        logic [3:0] argc;
        logic [3:0] jj;
        logic [3:0] rel;
        args[0] = i_arg_first;
        args[1] = i_arg_second;
        args[2] = i_arg_third;
        args[3] = i_arg_fourth;
        hlen    = is_long ? 4'd2 : 4'd1;
        argc    = (i_arg_count > 3'd4) ? 4'd4 : {1'b0, i_arg_count};
        hdr0    = is_long ? {r_toggle, 7'b0} : {i_command[3:0], r_toggle, 3'b0};
        case (i_arg_count)
            3'd1:    fmt = 8'd1;
            3'd2:    fmt = 8'd2;
            3'd4:    fmt = 8'd3;
            default: fmt = 8'd0;
        endcase
        fmt[2] = is_long;
        for (int j = 0; j < RAW_BYTES; j++) begin
            jj  = 4'(j);
            rel = jj - hlen;
            if (jj < hlen) begin
                n_raw[j] = (jj == 4'd0) ? hdr0 : i_command;
            end else if (rel < argc) begin
                n_raw[j] = args[rel[1:0]];
            end else if (rel == argc) begin
                n_raw[j] = i_device_address[7:0];
            end else if (rel == argc + 4'd1) begin
                n_raw[j] = i_device_address[15:8];
            end else if (rel == argc + 4'd2) begin
                n_raw[j] = fmt;
            end else begin
                n_raw[j] = 8'h00;
            end
        end
        n_raw_cnt = hlen + argc + 4'd3;
    end

    // Build step: one byte into the check and the store, check byte last
    assign build_last = (r_build_idx == r_raw_cnt);
    assign build_data = build_last ? r_crc : r_raw[0];
    assign len_full   = {1'b0, r_raw_cnt} + 5'd1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw <= n_raw;
        end else if (i_cmd.build_step) begin
            for (int j = 0; j < RAW_BYTES - 1; j++) begin
                r_raw[j] <= r_raw[j + 1];
            end
        end
        if (i_cmd.build_step && ({1'b0, r_build_idx} < STORE_DEPTH)) begin
            r_store[r_build_idx[IDX_W-1:0]] <= build_data;
        end
    end

    // Hold build and transmit control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_cnt   <= '0;
            r_build_idx <= '0;
            r_crc       <= '0;
            r_frame_len <= '0;
            r_shift     <= '0;
            r_toggle    <= 1'b0;
            r_pos       <= '0;
            r_half      <= 1'b0;
            r_repeats   <= '0;
            r_gap       <= '0;
        end else begin
            if (i_cmd.load) begin
                r_raw_cnt   <= n_raw_cnt;
                r_build_idx <= '0;
                r_crc       <= '0;
                r_shift     <= is_long ? 3'd7 : 3'd3;
                r_toggle    <= ~r_toggle;
                r_repeats   <= i_repeat_count;
                r_gap       <= '0;
            end
            if (i_cmd.build_step) begin
                r_build_idx <= r_build_idx + 4'd1;
                if (!build_last) begin
                    r_crc <= crc_byte(r_crc, r_raw[0]);
                end else begin
                    r_frame_len <= (len_full > STORE_DEPTH) ? STORE_DEPTH[3:0]
                                                            : len_full[3:0];
                end
            end
            if (i_cmd.rep_dec) begin
                r_repeats <= r_repeats - 8'd1;
            end
            if (i_cmd.rewind) begin
                r_pos  <= '0;
                r_half <= 1'b0;
            end else begin
                if (i_cmd.half_flip) begin
                    r_half <= ~r_half;
                end
                if (i_cmd.pos_inc) begin
                    r_pos <= r_pos + 7'd1;
                end
            end
            if (i_cmd.gap_load) begin
                r_gap <= i_gap_periods;
            end else if (i_cmd.gap_dec) begin
                r_gap <= r_gap - 3'd1;
            end
        end
    end

    // Pick the frame bit: start bit first, then the header from the shift on
    assign len_bits = {r_frame_len, 3'b000};
    assign q_pos    = r_pos + {4'd0, r_shift} - 7'd1;

    always_comb begin
        t_byte cur;
        cur = r_store[q_pos[3+IDX_W-1:3]];
        if (r_pos == 7'd0) begin
            bit_value = 1'b1;
        end else if ({2'b0, q_pos[6:3]} >= {1'b0, STORE_DEPTH}) begin
            bit_value = 1'b0;
        end else begin
            bit_value = cur[q_pos[2:0]];
        end
    end

    // Report status
    always_comb begin
        o_status.build_last   = build_last;
        o_status.half         = r_half;
        o_status.pre_last     = (r_pos == len_bits - 7'd1);
        o_status.frm_last     = (r_pos == len_bits - {4'd0, r_shift});
        o_status.bit_value    = bit_value;
        o_status.gap_one      = (r_gap == 3'd1);
        o_status.gap_cfg_zero = (i_gap_periods == 3'd0);
        o_status.rep_zero     = (r_repeats == 8'd0);
    end

endmodule
